// ----- hw/rtl/hdu_pkg.sv -----
package hdu_pkg;

  // Fixed character format
  localparam int DATA_BITS = 8;
  localparam int FRAME_W   = 11;
  localparam int IDX_W     = 4;
  localparam int PERIOD_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 2'd1;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;
  // floor(104 * 6 / 5)
  localparam logic [PERIOD_W-1:0] START_CMP_RST  = 16'd124;

  // Parity modes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_ODD  = 2'd1;
  localparam logic [1:0] PAR_EVEN = 2'd2;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  // Register settings as seen by the core
  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [PERIOD_W-1:0] start_cmp;   // saturated 1.2 bit periods
    logic [1:0]          parity_mode;
    logic                load_cmp;    // registered strobe of a bit period write
  } cfg_t;

  // One result
  typedef struct packed {
    logic                 tx_level;
    logic                 rx_valid;
    logic [DATA_BITS-1:0] rx_data;
    logic                 parity_error;
    logic                 send_accepted;
    logic                 rx_active;
    logic                 tx_active;
  } result_t;

  function automatic logic parity_on(input logic [1:0] mode);
    return (mode == PAR_ODD) || (mode == PAR_EVEN);
  endfunction

endpackage

// ----- hw/rtl/hdu_cfg.sv -----
module hdu_cfg
  import hdu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [PERIOD_W-1:0] bit_period_r;
  logic [PERIOD_W-1:0] start_cmp_r;
  logic [PERIOD_W-1:0] start_cmp_nxt;
  logic [1:0]          parity_mode_r;
  logic                load_cmp_r;
  logic                wr_period;
  logic [31:0]         fifth_prod;
  logic [PERIOD_W:0]   start_sum;

  assign cfg_ready = 1'b1;
  assign wr_period = cfg_valid && (cfg_index == CFG_BIT_PERIOD);

  // 1.2 periods = p + p/5; p/5 by reciprocal, exact for 16-bit p
  always_comb begin
    fifth_prod = cfg_wdata * 32'd52429;
    start_sum  = {1'b0, cfg_wdata} + {3'b000, fifth_prod[31:18]};
    start_cmp_nxt = start_sum[PERIOD_W] ? {PERIOD_W{1'b1}} : start_sum[PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      start_cmp_r   <= START_CMP_RST;
      parity_mode_r <= PAR_NONE;
      load_cmp_r    <= 1'b0;
    end else begin
      load_cmp_r <= 1'b0;
      if (wr_period) begin
        bit_period_r <= cfg_wdata;
        start_cmp_r  <= start_cmp_nxt;
        load_cmp_r   <= 1'b1;
      end
      if (cfg_valid && (cfg_index == CFG_PARITY_MODE)) begin
        parity_mode_r <= cfg_wdata[1:0];
      end
    end
  end

  assign cfg.bit_period  = bit_period_r;
  assign cfg.start_cmp   = start_cmp_r;
  assign cfg.parity_mode = parity_mode_r;
  assign cfg.load_cmp    = load_cmp_r;

endmodule

// ----- hw/rtl/hdu_core.sv -----
module hdu_core
  import hdu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 accept,
  input  logic                 req_type,
  input  logic                 rx_level,
  input  logic [DATA_BITS-1:0] tx_byte,
  output result_t              result
);

  logic [PERIOD_W-1:0]  tick_count_r, tick_count_nxt;
  logic [PERIOD_W-1:0]  compare_value_r, compare_value_nxt;
  logic                 last_rx_r, last_rx_nxt;
  logic                 receiving_r, receiving_nxt;
  logic [IDX_W-1:0]     rx_idx_r, rx_idx_nxt;
  logic [DATA_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic                 rx_par_r, rx_par_nxt;
  logic                 rx_bad_r, rx_bad_nxt;
  logic [FRAME_W-1:0]   tx_frame_r, tx_frame_nxt;
  logic [IDX_W-1:0]     tx_idx_r, tx_idx_nxt;
  logic                 tx_line_r, tx_line_nxt;

  logic                 par_en;
  logic                 byte_par;
  logic [PERIOD_W-1:0]  compare_cur;
  logic [PERIOD_W:0]    tick_sum;
  logic                 strobe;
  logic                 bad;
  logic [IDX_W-1:0]     rx_last;
  logic [IDX_W-1:0]     tx_last;

  // Next state for one request
  always_comb begin
    // a period written last cycle is already in force for this request
    compare_cur       = cfg.load_cmp ? cfg.bit_period : compare_value_r;

    tick_count_nxt    = tick_count_r;
    compare_value_nxt = compare_cur;
    last_rx_nxt       = last_rx_r;
    receiving_nxt     = receiving_r;
    rx_idx_nxt        = rx_idx_r;
    rx_shift_nxt      = rx_shift_r;
    rx_par_nxt        = rx_par_r;
    rx_bad_nxt        = rx_bad_r;
    tx_frame_nxt      = tx_frame_r;
    tx_idx_nxt        = tx_idx_r;
    tx_line_nxt       = tx_line_r;

    result.rx_valid      = 1'b0;
    result.rx_data       = '0;
    result.parity_error  = 1'b0;
    result.send_accepted = 1'b0;

    par_en   = parity_on(cfg.parity_mode);
    byte_par = ^tx_byte;
    tick_sum = {1'b0, tick_count_r} + {{PERIOD_W{1'b0}}, 1'b1};
    strobe   = 1'b0;
    bad      = 1'b0;
    rx_last  = par_en ? IDX_W'(DATA_BITS + 1) : IDX_W'(DATA_BITS);
    tx_last  = par_en ? IDX_W'(DATA_BITS + 2) : IDX_W'(DATA_BITS + 1);

    if (req_type == REQ_SEND) begin
      // send: only when the line is idle both ways
      if (!receiving_r && (tx_frame_r == '0)) begin
        if (cfg.parity_mode == PAR_ODD) begin
          tx_frame_nxt = {1'b1, ~byte_par, tx_byte, 1'b0};
        end else if (cfg.parity_mode == PAR_EVEN) begin
          tx_frame_nxt = {1'b1, byte_par, tx_byte, 1'b0};
        end else begin
          tx_frame_nxt = {2'b01, tx_byte, 1'b0};
        end
        tx_idx_nxt           = '0;
        result.send_accepted = 1'b1;
      end
    end else if (!receiving_r && last_rx_r && !rx_level) begin
      // start edge: abort transmit, aim first sample 1.2 bits on
      tx_line_nxt       = 1'b1;
      rx_shift_nxt      = '0;
      rx_idx_nxt        = '0;
      rx_par_nxt        = 1'b1;
      rx_bad_nxt        = 1'b0;
      receiving_nxt     = 1'b1;
      tx_idx_nxt        = '0;
      tx_frame_nxt      = '0;
      tick_count_nxt    = '0;
      compare_value_nxt = cfg.start_cmp;
      last_rx_nxt       = rx_level;
    end else begin
      // bit timer
      if (tick_sum >= {1'b0, compare_cur}) begin
        tick_count_nxt = '0;
        strobe         = 1'b1;
      end else begin
        tick_count_nxt = tick_sum[PERIOD_W-1:0];
      end
      last_rx_nxt = rx_level;

      if (strobe && receiving_r) begin
        if (rx_idx_r < IDX_W'(DATA_BITS)) begin
          if (rx_level) begin
            rx_shift_nxt[rx_idx_r[2:0]] = 1'b1;
            rx_par_nxt                  = ~rx_par_r;
          end
        end else if (par_en && (rx_idx_r == IDX_W'(DATA_BITS))) begin
          bad = (cfg.parity_mode == PAR_ODD) ? (rx_level != rx_par_r)
                                             : (rx_level == rx_par_r);
          if (bad) begin
            rx_shift_nxt = '0;
            rx_bad_nxt   = 1'b1;
          end
        end else if (rx_idx_r >= rx_last) begin
          receiving_nxt       = 1'b0;
          result.rx_valid     = 1'b1;
          result.rx_data      = rx_shift_r;
          result.parity_error = rx_bad_r;
        end
        if (rx_idx_r == '0) begin
          compare_value_nxt = cfg.bit_period;
        end
        if (rx_idx_r != {IDX_W{1'b1}}) begin
          rx_idx_nxt = rx_idx_r + IDX_W'(1);
        end
      end else if (strobe && (tx_frame_r != '0)) begin
        // drive next frame bit
        tx_line_nxt = (tx_idx_r < IDX_W'(FRAME_W)) ? tx_frame_r[tx_idx_r] : 1'b0;
        tx_idx_nxt  = tx_idx_r + IDX_W'(1);
        if (tx_idx_nxt > tx_last) begin
          tx_idx_nxt   = '0;
          tx_frame_nxt = '0;
        end
      end
    end

    result.tx_level  = tx_line_nxt;
    result.rx_active = receiving_nxt;
    result.tx_active = (tx_frame_nxt != '0);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= '0;
      compare_value_r <= BIT_PERIOD_RST;
      last_rx_r       <= 1'b1;
      receiving_r     <= 1'b0;
      rx_idx_r        <= '0;
      rx_shift_r      <= '0;
      rx_par_r        <= 1'b1;
      rx_bad_r        <= 1'b0;
      tx_frame_r      <= '0;
      tx_idx_r        <= '0;
      tx_line_r       <= 1'b1;
    end else if (accept) begin
      tick_count_r    <= tick_count_nxt;
      compare_value_r <= compare_value_nxt;
      last_rx_r       <= last_rx_nxt;
      receiving_r     <= receiving_nxt;
      rx_idx_r        <= rx_idx_nxt;
      rx_shift_r      <= rx_shift_nxt;
      rx_par_r        <= rx_par_nxt;
      rx_bad_r        <= rx_bad_nxt;
      tx_frame_r      <= tx_frame_nxt;
      tx_idx_r        <= tx_idx_nxt;
      tx_line_r       <= tx_line_nxt;
    end else if (cfg.load_cmp) begin
      compare_value_r <= cfg.bit_period;
    end
  end

endmodule

// ----- hw/rtl/hdu_out_reg.sv -----
module hdu_out_reg
  import hdu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  result_t result,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    hold,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // full and stalled: upstream must wait
  assign hold      = valid_r && out_stall;
  assign valid_nxt = accept || hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule

// ----- hw/rtl/half_duplex_uart_with_parity.sv -----
// Half-duplex 8-bit UART, LSB first, with none, odd or even parity. Each input
// request is either one base-clock tick carrying the sampled rx level or a
// request to send a byte; every request gives exactly one result, registered,
// in the cycle after it is taken. One request is taken per cycle whenever the
// result register is empty or being drained; a stalled result holds the input
// off. The bit timer, receiver and transmitter all update as each request is
// taken. The 1.2 bit-period start delay is worked out when bit_period is
// written, so it costs nothing at run time. Configuration writes are always
// ready and should be made while no request is in flight.
module half_duplex_uart_with_parity
  import hdu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic                  in_rx_level,
  input  logic [DATA_BITS-1:0]  in_tx_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_tx_level,
  output logic                  out_rx_valid,
  output logic [DATA_BITS-1:0]  out_rx_data,
  output logic                  out_parity_error,
  output logic                  out_send_accepted,
  output logic                  out_rx_active,
  output logic                  out_tx_active,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t result;
  result_t out_result;
  logic    hold;
  logic    accept;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  hdu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hdu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .req_type (in_req_type),
    .rx_level (in_rx_level),
    .tx_byte  (in_tx_byte),
    .result   (result)
  );

  hdu_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .result     (result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .hold       (hold),
    .out_result (out_result)
  );

  assign out_tx_level      = out_result.tx_level;
  assign out_rx_valid      = out_result.rx_valid;
  assign out_rx_data       = out_result.rx_data;
  assign out_parity_error  = out_result.parity_error;
  assign out_send_accepted = out_result.send_accepted;
  assign out_rx_active     = out_result.rx_active;
  assign out_tx_active     = out_result.tx_active;

endmodule
